### sv/stepped_sine_tone_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepped sine tone sequencer
// Clocked property wrappers, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef STEPPED_SINE_TONE_SEQUENCER_TOP_ASSERT_SVH
`define STEPPED_SINE_TONE_SEQUENCER_TOP_ASSERT_SVH

// property checked only while out of reset
`define SST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define SST_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants, types and the sine ROM generator.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int TABLE_DEPTH    = 8;
  localparam int SINE_ADDR_BITS = 10;
  localparam int OUT_BITS       = 16;

  localparam int IDX_BITS      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SEG_BITS      = $clog2(TABLE_DEPTH + 1);
  localparam int POS_BITS      = 24;
  localparam int AMP_BITS      = 15;
  localparam int TC_BITS       = 4;
  localparam int STEP_BITS     = 32;
  localparam int OP_BITS       = 2;
  localparam int ENTRY_BITS    = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int SINE_Q        = 1 << SINE_ADDR_BITS;
  localparam int ROM_ADDR_BITS = SINE_ADDR_BITS + 1;
  localparam int MAG_BITS      = OUT_BITS - 1;
  localparam int PROD_BITS     = MAG_BITS + AMP_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TONE_SAMPLES    = 2'd0,
    REG_SEGMENT_SAMPLES = 2'd1,
    REG_AMPLITUDE       = 2'd2,
    REG_TONE_COUNT      = 2'd3
  } cfg_reg_t;

  // per-sample sideband travelling with the ROM read
  typedef struct packed {
    logic tone_active;
    logic finished;
    logic negate;
  } smp_tag_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [0:SINE_Q];

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;
  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // quarter-wave table, Q2.30 Taylor series to x^13, round half up
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] fs;
    logic [63:0] scaled;
    longint      acc;
    fs = (64'd1 << (OUT_BITS - 1)) - 64'd1;
    for (int k = 0; k <= SINE_Q; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n & 1) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > ONE_Q30) begin
        acc = ONE_Q30;
      end
      scaled = (64'(acc) * fs + (64'd1 << 29)) >> 30;
      rom[k] = MAG_BITS'(scaled);
    end
    return rom;
  endfunction

endpackage

### sv/sst_if.sv
// ----------------------------------------------------------------------------
// sst_if
// Valid/ready channels: tick/write/restart input, sample output, config.
// ----------------------------------------------------------------------------
interface sst_in_if;
  import sst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    operation;
  logic [ENTRY_BITS-1:0] entry_index;
  logic [STEP_BITS-1:0]  phase_step;
  modport source (output valid, operation, entry_index, phase_step, input ready);
  modport sink   (input valid, operation, entry_index, phase_step, output ready);
endinterface

interface sst_out_if;
  import sst_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sample;
  logic                       tone_active;
  logic                       finished;
  modport source (output valid, sample, tone_active, finished, input ready);
  modport sink   (input valid, sample, tone_active, finished, output ready);
endinterface

interface sst_cfg_if;
  import sst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/sst_step_mem.sv
// ----------------------------------------------------------------------------
// sst_step_mem
// Phase step table: one write port, one registered read with write forwarding.
// ----------------------------------------------------------------------------
module sst_step_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sst_pkg::IDX_BITS-1:0]  waddr,
  input  logic [sst_pkg::STEP_BITS-1:0] wdata,
  input  logic [sst_pkg::IDX_BITS-1:0]  raddr,
  output logic [sst_pkg::STEP_BITS-1:0] rdata
);
  import sst_pkg::*;

  logic [STEP_BITS-1:0] mem [0:TABLE_DEPTH-1];
  logic [STEP_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-entry write wins over the stale array read
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/sst_sine_rom.sv
// ----------------------------------------------------------------------------
// sst_sine_rom
// Quarter-wave sine ROM with registered read and hold enable.
// ----------------------------------------------------------------------------
module sst_sine_rom (
  input  logic                              clk,
  input  logic                              en,
  input  logic [sst_pkg::ROM_ADDR_BITS-1:0] addr,
  output logic [sst_pkg::MAG_BITS-1:0]      rom_q
);
  import sst_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [MAG_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= SINE_ROM[addr];
    end
  end

  assign rom_q = q_r;

endmodule

### sv/sst_scale_pipe.sv
// ----------------------------------------------------------------------------
// sst_scale_pipe
// Amplitude multiply, rounding, sign and saturation, then the output register.
// ----------------------------------------------------------------------------
module sst_scale_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  sst_pkg::smp_tag_t            s1_tag,
  input  logic [sst_pkg::MAG_BITS-1:0] rom_q,
  input  logic [sst_pkg::AMP_BITS-1:0] amplitude,
  output logic                         s1_ready,
  sst_out_if.source                    out_ch
);
  import sst_pkg::*;

  localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (AMP_BITS - 1);
  localparam logic signed [OUT_BITS+1:0] SAT_HI =
    (OUT_BITS + 2)'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic signed [OUT_BITS+1:0] SAT_LO = -SAT_HI - 1;

  logic                 s2_v_r;
  smp_tag_t             s2_tag_r;
  logic [PROD_BITS-1:0] prod_r;

  logic                       out_v_r;
  logic signed [OUT_BITS-1:0] sample_r;
  logic                       tone_r;
  logic                       fin_r;

  logic                       out_adv;
  logic                       s2_ready;
  logic [PROD_BITS:0]         rnd;
  logic [OUT_BITS-1:0]        mag;
  logic signed [OUT_BITS+1:0] sval;
  logic signed [OUT_BITS-1:0] sample_nxt;

  assign out_adv  = !out_v_r || out_ch.ready;
  assign s2_ready = !s2_v_r || out_adv;
  assign s1_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_tag_r <= s1_tag;
      prod_r   <= PROD_BITS'(rom_q) * PROD_BITS'(amplitude);
    end
  end

  always_comb begin
    rnd  = {1'b0, prod_r} + ROUND_HALF;
    mag  = rnd[PROD_BITS:AMP_BITS];
    sval = signed'({2'b00, mag});
    if (s2_tag_r.negate) begin
      sval = -sval;
    end
    if (!s2_tag_r.tone_active) begin
      sample_nxt = '0;
    end else if (sval > SAT_HI) begin
      sample_nxt = SAT_HI[OUT_BITS-1:0];
    end else if (sval < SAT_LO) begin
      sample_nxt = SAT_LO[OUT_BITS-1:0];
    end else begin
      sample_nxt = sval[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      sample_r <= sample_nxt;
      tone_r   <= s2_tag_r.tone_active;
      fin_r    <= s2_tag_r.finished;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.sample      = sample_r;
  assign out_ch.tone_active = tone_r;
  assign out_ch.finished    = fin_r;

endmodule

### sv/stepped_sine_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// stepped_sine_tone_sequencer_top
// Stepped sine tone sequencer: tone/gap segments driven by a step table.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle, any mix of ticks, writes, restarts,
//   while out_ch is not stalled. A tick's sample passes the sine ROM read, the
//   amplitude multiply and the round/saturate into the output reg to out_ch.
// The rate is set by the step table's single registered read, which is
//   addressed with the next segment number so the step is ready for every tick.
// Reset: config registers, position, segment and phase clear to zero; the step
//   table is not cleared and must be written before a segment uses it.
// ----------------------------------------------------------------------------
module stepped_sine_tone_sequencer_top (
  input  logic      clk,
  input  logic      rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch,
  sst_cfg_if.sink   cfg_ch
);
  import sst_pkg::*;

  // configuration registers
  logic [POS_BITS-1:0] tone_samples_r;
  logic [POS_BITS-1:0] segment_samples_r;
  logic [AMP_BITS-1:0] amplitude_r;
  logic [TC_BITS-1:0]  tone_count_r;

  // sequencer state
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [SEG_BITS-1:0]  seg_r, seg_nxt;
  logic [STEP_BITS-1:0] phase_r, phase_nxt;

  // first pipeline stage: sideband next to the ROM read register
  logic     s1_v_r, s1_v_nxt;
  smp_tag_t s1_tag_r, s1_tag_nxt;
  logic     s1_ready;

  logic                 accept;
  logic [SEG_BITS-1:0]  count;
  logic                 empty;
  logic                 seg_end;
  logic                 tbl_we;
  logic [STEP_BITS-1:0] step_q;

  logic [SINE_ADDR_BITS+1:0] ph_idx;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] k_raw;
  logic [ROM_ADDR_BITS-1:0]  rom_addr;
  logic [MAG_BITS-1:0]       rom_q;

  // ---------------- configuration port: always ready ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_samples_r    <= '0;
      segment_samples_r <= '0;
      amplitude_r       <= '0;
      tone_count_r      <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_TONE_SAMPLES:    tone_samples_r    <= POS_BITS'(cfg_ch.data);
        REG_SEGMENT_SAMPLES: segment_samples_r <= POS_BITS'(cfg_ch.data);
        REG_AMPLITUDE:       amplitude_r       <= AMP_BITS'(cfg_ch.data);
        REG_TONE_COUNT:      tone_count_r      <= TC_BITS'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // ---------------- input handshake ----------------
  // Input stalls only when every stage downstream holds a waiting sample.
  assign in_ch.ready = s1_ready;
  assign accept      = in_ch.valid && s1_ready;

  // tone counts beyond the table act as a full table
  always_comb begin
    if (int'(tone_count_r) > TABLE_DEPTH) begin
      count = SEG_BITS'(TABLE_DEPTH);
    end else begin
      count = SEG_BITS'(tone_count_r);
    end
  end

  assign empty   = (count == '0) || (segment_samples_r == '0) || (seg_r >= count);
  assign seg_end = ({1'b0, pos_r} + (POS_BITS + 1)'(1)) >= {1'b0, segment_samples_r};

  // phase to quadrant and mirrored quarter-wave index
  assign ph_idx = phase_r[STEP_BITS-1 -: SINE_ADDR_BITS+2];
  assign quad   = ph_idx[SINE_ADDR_BITS+1:SINE_ADDR_BITS];
  assign k_raw  = ph_idx[SINE_ADDR_BITS-1:0];
  assign rom_addr = quad[0] ? (ROM_ADDR_BITS'(SINE_Q) - {1'b0, k_raw}) : {1'b0, k_raw};

  // ---------------- item decode and state update ----------------
  always_comb begin
    pos_nxt    = pos_r;
    seg_nxt    = seg_r;
    phase_nxt  = phase_r;
    tbl_we     = 1'b0;
    s1_v_nxt   = 1'b0;
    s1_tag_nxt = '{tone_active: 1'b0, finished: 1'b0, negate: quad[1]};
    if (accept) begin
      case (op_t'(in_ch.operation))
        OP_TICK: begin
          s1_v_nxt = 1'b1;
          if (empty) begin
            // empty sequence or past the last segment: silent, no advance
            s1_tag_nxt.finished = 1'b1;
          end else begin
            if (pos_r < tone_samples_r) begin
              s1_tag_nxt.tone_active = 1'b1;
              phase_nxt = phase_r + step_q;
            end
            if (seg_end) begin
              pos_nxt   = '0;
              seg_nxt   = seg_r + SEG_BITS'(1);
              phase_nxt = '0;
            end else begin
              pos_nxt = pos_r + POS_BITS'(1);
            end
          end
        end
        OP_WRITE: begin
          if (int'(in_ch.entry_index) < TABLE_DEPTH) begin
            tbl_we = 1'b1;
          end
        end
        OP_RESTART: begin
          pos_nxt   = '0;
          seg_nxt   = '0;
          phase_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      seg_r   <= '0;
      phase_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_tag_r <= s1_tag_nxt;
    end
  end

  // ---------------- step table: read the segment that comes next ----------------
  sst_step_mem u_step_mem (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_BITS'(in_ch.entry_index)),
    .wdata (in_ch.phase_step),
    .raddr (IDX_BITS'(seg_nxt)),
    .rdata (step_q)
  );

  // ---------------- sine lookup, loaded with the first stage ----------------
  sst_sine_rom u_sine_rom (
    .clk   (clk),
    .en    (s1_ready),
    .addr  (rom_addr),
    .rom_q (rom_q)
  );

  // ---------------- gain, saturation, output register ----------------
  sst_scale_pipe u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_v_r),
    .s1_tag    (s1_tag_r),
    .rom_q     (rom_q),
    .amplitude (amplitude_r),
    .s1_ready  (s1_ready),
    .out_ch    (out_ch)
  );

endmodule

### sv/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "stepped_sine_tone_sequencer_top_assert.svh"

module sst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sst_pkg::OUT_BITS-1:0] out_sample,
  input logic                              out_tone_active,
  input logic                              out_finished
);
  import sst_pkg::*;

  // a stalled result keeps its payload
  `SST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_tone_active) && $stable(out_finished), "stalled result changed")

  // past the end means silence
  `SST_ASSERT(a_finished_silent, clk, rst_n, out_valid && out_finished |-> !out_tone_active && (out_sample == '0), "finished sample not silent")

  // with the output register empty nothing can block the input
  `SST_ASSERT(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")

  // reset flushes any pending result
  `SST_ASSERT_NR(a_reset_flush, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind stepped_sine_tone_sequencer_top sst_checker u_sst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_sample      (out_ch.sample),
  .out_tone_active (out_ch.tone_active),
  .out_finished    (out_ch.finished)
);
